### rtl/lzss_stream_decoder_core_assert.svh
// Assertion macros for the LZSS stream decoder.
// Included by modules that check their own logic; no other dependencies.
`ifndef LZSS_STREAM_DECODER_CORE_ASSERT_SVH
`define LZSS_STREAM_DECODER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define LZSS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lzss assertion failed");
`define LZSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lzss assertion failed");
`else
`define LZSS_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define LZSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### rtl/lzss_pkg.sv
// Shared types, codes and constants of the LZSS stream decoder.
// No dependencies; used by every module of the decoder.
`timescale 1ns / 1ps

package lzss_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHEAD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 2'd1;

    localparam logic [11:0] LOOKAHEAD_RST = 12'd18;
    localparam logic [31:0] LIMIT_RST     = 32'hFFFF_FFFF;

    localparam int RING_AW_DEF   = 12;
    localparam int CMD_DEPTH_DEF = 4;

    localparam logic [7:0] SPACE_BYTE = 8'h20;
    localparam logic [3:0] FLAG_GROUP = 4'd8;
    // A match copies len + 3 bytes, so its last copy index is len + 2.
    localparam logic [4:0] MATCH_LAST_BIAS = 5'd2;

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        data_valid;
        logic        run_last;
        logic [1:0]  status;
        logic [31:0] consumed_count;
        logic [31:0] produced_count;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_LIT,
        CMD_MATCH
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  data;
        logic [11:0] off;
        logic [3:0]  len;
        logic        last;
    } cmd_t;

    function automatic logic [1:0] end_status(input logic hit, input logic last);
        logic [1:0] st;
        if (hit) begin
            st = ST_DONE;
        end else if (last) begin
            st = ST_ERR;
        end else begin
            st = ST_RUN;
        end
        return st;
    endfunction

endpackage

### rtl/lzss_front.sv
// Front end of the LZSS decoder: parses flag bytes and token bytes into commands.
// Depends on lzss_pkg.
`timescale 1ns / 1ps

module lzss_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  lzss_pkg::in_item_t s_data,
    output logic              push_valid,
    input  logic              push_ready,
    output lzss_pkg::cmd_t    push_cmd
);
    import lzss_pkg::*;

    logic [7:0] flag_shift_reg, flag_shift_next;
    logic [3:0] flags_left_reg, flags_left_next;
    logic       phase_reg, phase_next;
    logic [7:0] offset_low_reg, offset_low_next;
    logic       accept;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;
    assign accept     = s_valid && push_ready;

    always_comb begin
        flag_shift_next = flag_shift_reg;
        flags_left_next = flags_left_reg;
        phase_next      = phase_reg;
        offset_low_next = offset_low_reg;
        push_cmd.kind   = CMD_NONE;
        push_cmd.data   = s_data.in_byte;
        push_cmd.off    = {s_data.in_byte[7:4], offset_low_reg};
        push_cmd.len    = s_data.in_byte[3:0];
        push_cmd.last   = s_data.in_last;

        if (phase_reg) begin
            push_cmd.kind   = CMD_MATCH;
            flag_shift_next = flag_shift_reg >> 1;
            flags_left_next = flags_left_reg - 4'd1;
            phase_next      = 1'b0;
        end else if (flags_left_reg == 4'd0) begin
            flag_shift_next = s_data.in_byte;
            flags_left_next = FLAG_GROUP;
        end else if (flag_shift_reg[0]) begin
            push_cmd.kind   = CMD_LIT;
            flag_shift_next = flag_shift_reg >> 1;
            flags_left_next = flags_left_reg - 4'd1;
        end else begin
            offset_low_next = s_data.in_byte;
            phase_next      = 1'b1;
        end

        // The parser restarts with every new stream.
        if (s_data.in_last) begin
            flag_shift_next = '0;
            flags_left_next = '0;
            phase_next      = 1'b0;
            offset_low_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_shift_reg <= '0;
            flags_left_reg <= '0;
            phase_reg      <= 1'b0;
            offset_low_reg <= '0;
        end else if (accept) begin
            flag_shift_reg <= flag_shift_next;
            flags_left_reg <= flags_left_next;
            phase_reg      <= phase_next;
            offset_low_reg <= offset_low_next;
        end
    end

endmodule

### rtl/lzss_cmd_fifo.sv
// Short command queue between the front and back ends of the LZSS decoder.
// Depends on lzss_pkg; DEPTH must be a power of two.
`timescale 1ns / 1ps

module lzss_cmd_fifo #(
    parameter int DEPTH = lzss_pkg::CMD_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  lzss_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output lzss_pkg::cmd_t pop_cmd
);
    import lzss_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam logic [PW:0] FULL_COUNT = (PW + 1)'(DEPTH);

    cmd_t          entries [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;
    logic          push, pop;

    assign push_ready = (count_reg != FULL_COUNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entries[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### rtl/lzss_back.sv
// Back end of the LZSS decoder: executes commands against the ring window,
// keeps the stream counters and drives the output register. Depends on lzss_pkg.
`timescale 1ns / 1ps
`include "lzss_stream_decoder_core_assert.svh"

module lzss_back #(
    parameter int RING_AW = lzss_pkg::RING_AW_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  lzss_pkg::cmd_t      q_cmd,
    input  logic [11:0]         lookahead_i,
    input  logic [31:0]         limit_i,
    output logic                m_valid,
    input  logic                m_ready,
    output lzss_pkg::out_item_t m_data
);
    import lzss_pkg::*;

    localparam int RING_SIZE = 1 << RING_AW;
    localparam logic [RING_AW:0] FILL_MAX = (RING_AW + 1)'(RING_SIZE);

    typedef enum logic {
        S_IDLE,
        S_MATCH
    } state_t;

    state_t             state_reg, state_next;
    logic [31:0]        in_cnt_reg, in_cnt_next;
    logic [31:0]        out_cnt_reg, out_cnt_next;
    logic               fin_reg, fin_next;
    logic [RING_AW-1:0] wp_reg, wp_next;
    logic [RING_AW-1:0] start_reg, start_next;
    // Entries written since the stream began; everything else reads as a space.
    logic [RING_AW:0]   fill_reg, fill_next;
    logic [RING_AW-1:0] off_reg, off_next;
    logic [3:0]         len_reg, len_next;
    logic               last_reg, last_next;
    logic [4:0]         k_reg, k_next;
    logic               have_data_reg, have_data_next;
    logic               byp_sel_reg, byp_sel_next;
    logic [7:0]         byp_data_reg, byp_data_next;
    logic               unwr_reg, unwr_next;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg, m_data_next;

    logic [7:0]         ring [RING_SIZE];
    logic [7:0]         rd_q_reg;

    logic               slot_free;
    logic               wr_en;
    logic [7:0]         wr_data;
    logic               rd_en;
    logic [RING_AW-1:0] rd_addr;
    logic [RING_AW-1:0] rd_rel;
    logic [31:0]        prod_cnt;
    logic               hit;
    logic               match_end;
    logic [7:0]         match_byte;
    logic [RING_AW-1:0] wp_start;
    logic               emit;
    out_item_t          emit_item;
    logic               restart;

    assign slot_free  = !m_valid_reg || m_ready;
    assign prod_cnt   = out_cnt_reg + 32'd1;
    assign hit        = (prod_cnt >= limit_i);
    assign wp_start   = RING_AW'(12'd0 - lookahead_i);
    assign match_byte = byp_sel_reg ? byp_data_reg : (unwr_reg ? SPACE_BYTE : rd_q_reg);
    assign match_end  = (k_reg == ({1'b0, len_reg} + MATCH_LAST_BIAS)) || hit;
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

    always_comb begin
        state_next     = state_reg;
        in_cnt_next    = in_cnt_reg;
        out_cnt_next   = out_cnt_reg;
        fin_next       = fin_reg;
        wp_next        = wp_reg;
        start_next     = start_reg;
        fill_next      = fill_reg;
        off_next       = off_reg;
        len_next       = len_reg;
        last_next      = last_reg;
        k_next         = k_reg;
        have_data_next = have_data_reg;
        byp_sel_next   = byp_sel_reg;
        byp_data_next  = byp_data_reg;
        unwr_next      = unwr_reg;
        q_ready        = 1'b0;
        wr_en          = 1'b0;
        wr_data        = q_cmd.data;
        rd_en          = 1'b0;
        rd_addr        = off_reg + RING_AW'(k_reg);
        rd_rel         = '0;
        emit           = 1'b0;
        emit_item      = '0;
        restart        = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    if (fin_reg) begin
                        // Stream already succeeded: drop the item, counts stay frozen.
                        if (slot_free) begin
                            q_ready                  = 1'b1;
                            emit                     = 1'b1;
                            emit_item.run_last       = 1'b1;
                            emit_item.status         = ST_DONE;
                            emit_item.consumed_count = in_cnt_reg;
                            emit_item.produced_count = out_cnt_reg;
                            restart                  = q_cmd.last;
                        end
                    end else begin
                        case (q_cmd.kind)
                            CMD_MATCH: begin
                                q_ready        = 1'b1;
                                in_cnt_next    = in_cnt_reg + 32'd1;
                                off_next       = q_cmd.off[RING_AW-1:0];
                                len_next       = q_cmd.len;
                                last_next      = q_cmd.last;
                                k_next         = '0;
                                have_data_next = 1'b0;
                                state_next     = S_MATCH;
                            end
                            CMD_LIT: begin
                                if (slot_free) begin
                                    q_ready                  = 1'b1;
                                    in_cnt_next              = in_cnt_reg + 32'd1;
                                    wr_en                    = 1'b1;
                                    wr_data                  = q_cmd.data;
                                    wp_next                  = wp_reg + 1'b1;
                                    fill_next = (fill_reg == FILL_MAX) ? fill_reg
                                                                       : fill_reg + 1'b1;
                                    out_cnt_next             = prod_cnt;
                                    fin_next                 = hit;
                                    emit                     = 1'b1;
                                    emit_item.out_byte       = q_cmd.data;
                                    emit_item.data_valid     = 1'b1;
                                    emit_item.run_last       = 1'b1;
                                    emit_item.status         = end_status(hit, q_cmd.last);
                                    emit_item.consumed_count = in_cnt_reg + 32'd1;
                                    emit_item.produced_count = prod_cnt;
                                    restart                  = q_cmd.last;
                                end
                            end
                            default: begin
                                if (slot_free) begin
                                    q_ready                  = 1'b1;
                                    in_cnt_next              = in_cnt_reg + 32'd1;
                                    emit                     = 1'b1;
                                    emit_item.run_last       = 1'b1;
                                    emit_item.status         = end_status(1'b0, q_cmd.last);
                                    emit_item.consumed_count = in_cnt_reg + 32'd1;
                                    emit_item.produced_count = out_cnt_reg;
                                    restart                  = q_cmd.last;
                                end
                            end
                        endcase
                    end
                end
            end
            S_MATCH: begin
                if (!have_data_reg) begin
                    rd_en          = 1'b1;
                    rd_addr        = off_reg + RING_AW'(k_reg);
                    have_data_next = 1'b1;
                    byp_sel_next   = 1'b0;
                end else if (slot_free) begin
                    wr_en                    = 1'b1;
                    wr_data                  = match_byte;
                    wp_next                  = wp_reg + 1'b1;
                    fill_next = (fill_reg == FILL_MAX) ? fill_reg : fill_reg + 1'b1;
                    out_cnt_next             = prod_cnt;
                    fin_next                 = hit;
                    emit                     = 1'b1;
                    emit_item.out_byte       = match_byte;
                    emit_item.data_valid     = 1'b1;
                    emit_item.run_last       = match_end;
                    emit_item.status = match_end ? end_status(hit, last_reg) : ST_RUN;
                    emit_item.consumed_count = in_cnt_reg;
                    emit_item.produced_count = prod_cnt;
                    if (match_end) begin
                        state_next = S_IDLE;
                        restart    = last_reg;
                    end else begin
                        // Fetch the next source byte; if it is the one being written
                        // now, take it from the write path instead of the memory.
                        k_next        = k_reg + 5'd1;
                        rd_en         = 1'b1;
                        rd_addr       = off_reg + RING_AW'(k_reg) + 1'b1;
                        byp_sel_next  = (rd_addr == wp_reg);
                        byp_data_next = match_byte;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (rd_en) begin
            rd_rel    = rd_addr - start_reg;
            unwr_next = ({1'b0, rd_rel} >= fill_reg);
        end

        if (restart) begin
            in_cnt_next  = '0;
            out_cnt_next = '0;
            fin_next     = 1'b0;
            wp_next      = wp_start;
            start_next   = wp_start;
            fill_next    = '0;
        end

        m_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        m_data_next  = emit ? emit_item : m_data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            in_cnt_reg    <= '0;
            out_cnt_reg   <= '0;
            fin_reg       <= 1'b0;
            wp_reg        <= RING_AW'(12'd0 - LOOKAHEAD_RST);
            start_reg     <= RING_AW'(12'd0 - LOOKAHEAD_RST);
            fill_reg      <= '0;
            have_data_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            in_cnt_reg    <= in_cnt_next;
            out_cnt_reg   <= out_cnt_next;
            fin_reg       <= fin_next;
            wp_reg        <= wp_next;
            start_reg     <= start_next;
            fill_reg      <= fill_next;
            have_data_reg <= have_data_next;
            m_valid_reg   <= m_valid_next;
        end
        off_reg      <= off_next;
        len_reg      <= len_next;
        last_reg     <= last_next;
        k_reg        <= k_next;
        byp_sel_reg  <= byp_sel_next;
        byp_data_reg <= byp_data_next;
        unwr_reg     <= unwr_next;
        m_data_reg   <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring[wp_reg] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg <= ring[rd_addr];
        end
    end

    `LZSS_ASSERT_IMPL(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= FILL_MAX)
    `LZSS_ASSERT_IMPL(a_copy_bound, aclk, aresetn, state_reg == S_MATCH, k_reg <= ({1'b0, len_reg} + MATCH_LAST_BIAS))
    `LZSS_ASSERT_IMPL(a_status_on_last, aclk, aresetn, m_valid_reg && (m_data_reg.status != ST_RUN), m_data_reg.run_last)
    `LZSS_ASSERT_NEXT(a_done_frozen, aclk, aresetn, fin_reg && !restart, out_cnt_reg == $past(out_cnt_reg))
    `LZSS_ASSERT_NEXT(a_restart_clears, aclk, aresetn, restart, (in_cnt_reg == '0) && (fill_reg == '0) && !fin_reg)

endmodule

### rtl/lzss_stream_decoder_core.sv
// LZSS stream decoder, 4K ring window. An item enters the command queue at acceptance;
// a flag, literal or first match byte offers its single result from the output register
// once the back end pops it from the queue. A match of L bytes runs a queue pop, the first
// ring read, then one byte per cycle while the output is free, through one ring read port.
// Reset is synchronous and active low; the ring needs no clearing pass, because a fill
// count marks which entries the current stream has written.
`timescale 1ns / 1ps

module lzss_stream_decoder_core #(
    parameter int RING_AW   = lzss_pkg::RING_AW_DEF,
    parameter int CMD_DEPTH = lzss_pkg::CMD_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  lzss_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output lzss_pkg::out_item_t                 m_data,
    input  logic                                cfg_we,
    input  logic [lzss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lzss_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import lzss_pkg::*;

    logic [11:0] lookahead_reg, lookahead_next;
    logic [31:0] limit_reg, limit_next;

    logic push_valid, push_ready;
    cmd_t push_cmd;
    logic pop_valid, pop_ready;
    cmd_t pop_cmd;

    always_comb begin
        lookahead_next = lookahead_reg;
        limit_next     = limit_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_LOOKAHEAD: lookahead_next = cfg_wdata[11:0];
                CFG_LIMIT:     limit_next     = cfg_wdata[31:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lookahead_reg <= LOOKAHEAD_RST;
            limit_reg     <= LIMIT_RST;
        end else begin
            lookahead_reg <= lookahead_next;
            limit_reg     <= limit_next;
        end
    end

    lzss_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    lzss_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    lzss_back #(
        .RING_AW (RING_AW)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (pop_valid),
        .q_ready     (pop_ready),
        .q_cmd       (pop_cmd),
        .lookahead_i (lookahead_reg),
        .limit_i     (limit_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

### dv/testbench.sv
// Self-checking testbench for lzss_stream_decoder_core: directed and random compressed streams,
// each checked against a behavioral decoder kept in this file.
// Depends on lzss_pkg and the lzss_stream_decoder_core RTL only.
`timescale 1ns / 1ps

module testbench;
    import lzss_pkg::*;

    localparam int WINDOW       = 4096;
    // Slowest run: about 200 items at 18 results, each result stalled, plus holds and drains.
    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 24;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    lzss_stream_decoder_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Behavioral decoder state.
    logic [7:0]  win [WINDOW];
    logic [11:0] win_pos;
    logic [7:0]  flag_bits;
    logic [3:0]  flags_rem;
    logic        second_half;
    logic [7:0]  off_lo;
    logic [31:0] src_cnt;
    logic [31:0] dec_cnt;
    logic        stream_done;
    logic [11:0] cfg_lookahead;
    logic [31:0] cfg_limit;

    out_item_t   step_out[$];
    out_item_t   pending_results[$];
    out_item_t   want;

    int          errors = 0;
    int          fresh_items = 0;
    int          cycle_count = 0;
    int          send_gap_pct = 0;
    int          stall_pct = 0;
    int          hold_id = 0;
    int          hold_seen = 0;
    int          hold_cnt = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function void restart_stream();
        for (int i = 0; i < WINDOW; i++) begin
            win[i] = SPACE_BYTE;
        end
        win_pos     = 12'd0 - cfg_lookahead;
        flag_bits   = 8'd0;
        flags_rem   = 4'd0;
        second_half = 1'b0;
        off_lo      = 8'd0;
        src_cnt     = 32'd0;
        dec_cnt     = 32'd0;
        stream_done = 1'b0;
    endfunction

    function void emit_byte(input logic [7:0] b);
        out_item_t r;
        win[win_pos] = b;
        win_pos      = win_pos + 12'd1;
        dec_cnt      = dec_cnt + 32'd1;
        r.out_byte       = b;
        r.data_valid     = 1'b1;
        r.run_last       = 1'b0;
        r.status         = ST_RUN;
        r.consumed_count = src_cnt;
        r.produced_count = dec_cnt;
        step_out.push_back(r);
        if (dec_cnt >= cfg_limit) begin
            stream_done = 1'b1;
        end
    endfunction

    // Works out every result that one accepted item causes and queues them.
    function void decode_step(input in_item_t it);
        logic [11:0] rd;
        logic [4:0]  len;
        out_item_t   r;
        step_out.delete();
        if (!stream_done) begin
            src_cnt = src_cnt + 32'd1;
            if (second_half) begin
                rd          = {it.in_byte[7:4], off_lo};
                len         = {1'b0, it.in_byte[3:0]} + 5'd3;
                flag_bits   = flag_bits >> 1;
                flags_rem   = flags_rem - 4'd1;
                second_half = 1'b0;
                // Reading after each write lets a match copy its own output.
                for (int k = 0; k < len && !stream_done; k++) begin
                    emit_byte(win[rd]);
                    rd = rd + 12'd1;
                end
            end else if (flags_rem == 4'd0) begin
                flag_bits = it.in_byte;
                flags_rem = FLAG_GROUP;
            end else if (flag_bits[0]) begin
                flag_bits = flag_bits >> 1;
                flags_rem = flags_rem - 4'd1;
                emit_byte(it.in_byte);
            end else begin
                off_lo      = it.in_byte;
                second_half = 1'b1;
            end
        end
        if (step_out.size() == 0) begin
            r.out_byte       = 8'd0;
            r.data_valid     = 1'b0;
            r.run_last       = 1'b0;
            r.status         = ST_RUN;
            r.consumed_count = src_cnt;
            r.produced_count = dec_cnt;
            step_out.push_back(r);
        end
        r          = step_out.pop_back();
        r.run_last = 1'b1;
        r.status   = stream_done ? ST_DONE : (it.in_last ? ST_ERR : ST_RUN);
        step_out.push_back(r);
        foreach (step_out[i]) begin
            pending_results.push_back(step_out[i]);
        end
        if (it.in_last) begin
            restart_stream();
        end
    endfunction

    task automatic send_item(input in_item_t it);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        if (!stream_done) begin
            fresh_items++;
        end
        decode_step(it);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        in_item_t it;
        it.in_byte = b;
        it.in_last = last;
        send_item(it);
    endtask

    task automatic send_match(input logic [11:0] off, input logic [3:0] len, input logic last);
        send_byte(off[7:0], 1'b0);
        send_byte({off[11:8], len}, last);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_LOOKAHEAD) begin
            cfg_lookahead = val[11:0];
        end else if (idx == CFG_LIMIT) begin
            cfg_limit = val;
        end
        @(posedge aclk);
    endtask

    // Lowers valid and waits until every expected result has come out, then a little more.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Mostly well-formed streams with random content; the rest is loose noise.
    task automatic send_random_stream();
        int          n_tok;
        int          n;
        logic [7:0]  flags;
        logic [11:0] off;
        if ($urandom_range(0, 99) < 80) begin
            n_tok = $urandom_range(1, 12);
            for (int t = 0; t < n_tok; t++) begin
                if (t % 8 == 0) begin
                    flags = 8'($urandom);
                    send_byte(flags, 1'b0);
                end
                if (flags[t % 8]) begin
                    send_byte(8'($urandom), t == n_tok - 1);
                end else begin
                    // Short distances make matches hit freshly written bytes.
                    if ($urandom_range(0, 99) < 65) begin
                        off = win_pos - 12'($urandom_range(1, 24));
                    end else begin
                        off = 12'($urandom);
                    end
                    send_match(off, 4'($urandom), t == n_tok - 1);
                end
            end
        end else begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) begin
                send_byte(8'($urandom), (i == n - 1) || ($urandom_range(0, 9) == 0));
            end
        end
    endtask

    task automatic test_token_kinds();
        send_byte(8'h05, 1'b0);
        send_byte(8'h00, 1'b0);
        send_match(12'h000, 4'h0, 1'b0);
        send_byte(8'hFF, 1'b0);
        // Longest match, overlapping its own output and wrapping the window end.
        send_match(win_pos - 12'd1, 4'hF, 1'b0);
        // The input runs out on the last byte of a match.
        send_match(12'hFFF, 4'h7, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h12, 1'b1);
    endtask

    task automatic test_output_limit();
        drain();
        cfg_write(CFG_LIMIT, 32'd4);
        cfg_write(CFG_LOOKAHEAD, 32'd0);
        // The limit cuts this match short; the following items are dropped.
        send_byte(8'h00, 1'b0);
        send_match(win_pos - 12'd2, 4'hF, 1'b0);
        send_byte(8'hAB, 1'b0);
        send_byte(8'h55, 1'b1);
        drain();
        cfg_write(CFG_LIMIT, 32'd0);
        cfg_write(CFG_LOOKAHEAD, 32'd4095);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        drain();
        cfg_write(CFG_LIMIT, 32'd1);
        send_byte(8'h00, 1'b0);
        send_match(12'h000, 4'h0, 1'b0);
        send_byte(8'h3C, 1'b1);
    endtask

    task automatic test_random_traffic(input int gap, input int stall, input logic [11:0] la,
                                       input logic [31:0] limit, input int n_items);
        int goal;
        drain();
        send_gap_pct <= gap;
        stall_pct    <= stall;
        cfg_write(CFG_LOOKAHEAD, {20'd0, la});
        cfg_write(CFG_LIMIT, limit);
        // A one-item stream so that the new lookahead takes effect.
        send_byte(8'($urandom), 1'b1);
        goal = fresh_items + n_items;
        while (fresh_items < goal) begin
            send_random_stream();
        end
    endtask

    task automatic test_backpressure();
        drain();
        send_gap_pct <= 0;
        stall_pct    <= 0;
        cfg_write(CFG_LIMIT, LIMIT_RST);
        send_byte(8'h00, 1'b1);
        hold_id <= hold_id + 1;
        send_byte(8'h00, 1'b0);
        for (int i = 0; i < 4; i++) begin
            send_match(12'($urandom), 4'hF, i == 3);
        end
    endtask

    // Result side: random stalls, and a long hold-off when one is requested.
    always @(posedge aclk) begin
        if (hold_id != hold_seen) begin
            hold_seen <= hold_id;
            hold_cnt  <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready  <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: byte %02h valid %0b last %0b status %0d",
                         $time, m_data.out_byte, m_data.data_valid, m_data.run_last,
                         m_data.status);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.out_byte !== want.out_byte || m_data.data_valid !== want.data_valid ||
                    m_data.run_last !== want.run_last || m_data.status !== want.status ||
                    m_data.consumed_count !== want.consumed_count ||
                    m_data.produced_count !== want.produced_count) begin
                    $display("%0t: expected byte %02h valid %0b last %0b st %0d in %0d out %0d",
                             $time, want.out_byte, want.data_valid, want.run_last, want.status,
                             want.consumed_count, want.produced_count);
                    $display("%0t: actual   byte %02h valid %0b last %0b st %0d in %0d out %0d",
                             $time, m_data.out_byte, m_data.data_valid, m_data.run_last,
                             m_data.status, m_data.consumed_count, m_data.produced_count);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_LOOKAHEAD;
        cfg_wdata <= '0;
        cfg_lookahead = LOOKAHEAD_RST;
        cfg_limit     = LIMIT_RST;
        restart_stream();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_token_kinds();
        test_output_limit();
        test_random_traffic(0, 0, LOOKAHEAD_RST, LIMIT_RST, 11);
        test_random_traffic(45, 0, 12'd1, 32'($urandom_range(8, 40)), 11);
        test_random_traffic(0, 45, 12'd4095, LIMIT_RST, 11);
        test_random_traffic(38, 38, 12'($urandom), 32'($urandom_range(1, 80)), 11);
        test_backpressure();
        drain();

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
